// ----- rtl/spi_serial_sram_slave_unit_defines.svh -----
// Assertion helpers for the serial SRAM slave.
`ifndef SPI_SERIAL_SRAM_SLAVE_UNIT_DEFINES_SVH
`define SPI_SERIAL_SRAM_SLAVE_UNIT_DEFINES_SVH

// checked only out of reset
`define SSRAM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SSRAM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/ssram_pkg.sv -----
package ssram_pkg;

    localparam logic [7:0] CMD_READ   = 8'h03;
    localparam logic [7:0] CMD_WRITE  = 8'h02;
    localparam logic [7:0] CMD_RDMODE = 8'h05;
    localparam logic [7:0] CMD_WRMODE = 8'h01;

    localparam logic [1:0] MODE_SEQUENTIAL = 2'd1;

    // what the answer byte of one word is made of
    typedef enum logic [1:0] {
        REPLY_ZERO,
        REPLY_MEM,
        REPLY_MODE
    } t_reply;

    typedef struct packed {
        logic   wr_en;
        logic   rd_en;
        t_reply reply;
    } t_step;

endpackage

// ----- rtl/spi_serial_sram_slave_unit.sv -----
// Slave side of a byte-wide SPI serial SRAM, sequential mode.
// Input stream: one word per SPI byte. s_axis_tdata is the byte from the host,
// s_axis_tuser is high on the first byte after chip select (the command).
// Output stream: one word per input word, in order, m_axis_tdata being the
// byte shifted back to the host (read data, mode register in bits 7:6, else 0).
// Commands: read, write (each with a 24-bit address, MSB first, then data with
// address auto-increment and wrap), read mode, write mode.
// Path from input acceptance to m_axis_tvalid: stage 1 issues the memory
// access and registers the read data, then the output register. Throughput:
// one word per cycle while the output is taken, the single-port-write/read
// SRAM taking one access per word.
// Reset (synchronous, i_rst_n low) clears the command decoder, the address,
// sets the mode to sequential and empties the pipeline; memory contents are
// not cleared and read as undefined until written.
// When m_axis_tready is low the output word holds and the stage behind it
// fills; s_axis_tready then drops until the output is taken.
module spi_serial_sram_slave_unit #(
    parameter int ADDR_BITS = 17
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] frame_start
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [7:0] out_byte
);

    logic                  w_accept;
    logic                  w_s1_move;
    ssram_pkg::t_step      w_step;
    logic [ADDR_BITS-1:0]  w_addr;
    logic [1:0]            w_mode;
    logic [7:0]            w_rd_data;
    logic [7:0]            w_reply;

    logic                  r_s1_valid;
    ssram_pkg::t_reply     r_s1_reply;
    logic [1:0]            r_s1_mode;
    logic                  r_out_valid;
    logic [7:0]            r_out_data;

    assign w_s1_move     = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_move;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    ssram_ctrl #(
        .ADDR_BITS(ADDR_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_frame_start (s_axis_tuser),
        .i_byte        (s_axis_tdata),
        .o_step        (w_step),
        .o_addr        (w_addr),
        .o_mode        (w_mode)
    );

    // read data stays put while stage 1 is stalled, as no new word is taken
    ssram_ram #(
        .WIDTH(8),
        .DEPTH(2 ** ADDR_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_step.wr_en),
        .i_wr_addr (w_addr),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (w_step.rd_en),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        case (r_s1_reply)
            ssram_pkg::REPLY_MEM:  w_reply = w_rd_data;
            ssram_pkg::REPLY_MODE: w_reply = {r_s1_mode, 6'b0};
            default:               w_reply = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_reply <= w_step.reply;
            r_s1_mode  <= w_mode;
        end
        if (w_s1_move) begin
            r_out_data <= w_reply;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/ssram_ram.sv -----
module ssram_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/ssram_ctrl.sv -----
module ssram_ctrl #(
    parameter int ADDR_BITS = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_frame_start,
    input  logic [7:0]           i_byte,
    output ssram_pkg::t_step     o_step,
    output logic [ADDR_BITS-1:0] o_addr,
    output logic [1:0]           o_mode
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDR_HI,
        PH_ADDR_MID,
        PH_ADDR_LO,
        PH_DATA,
        PH_MODE_LOAD,
        PH_MODE_SHOW,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_READ,
        KIND_WRITE
    } t_kind;

    t_phase                r_phase, n_phase;
    t_kind                 r_kind, n_kind;
    logic [ADDR_BITS-1:0]  r_addr, n_addr;
    logic [1:0]            r_mode, n_mode;
    logic [ADDR_BITS+7:0]  w_shift;
    ssram_pkg::t_step      w_step;

    // address byte shifted in; bits above the memory size fall off
    assign w_shift = {r_addr, i_byte};

    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_addr  = r_addr;
        n_mode  = r_mode;
        w_step  = '{wr_en: 1'b0, rd_en: 1'b0, reply: ssram_pkg::REPLY_ZERO};
        if (i_accept) begin
            if (i_frame_start) begin
                n_kind = KIND_NONE;
                unique case (i_byte)
                    ssram_pkg::CMD_READ: begin
                        n_kind  = KIND_READ;
                        n_phase = PH_ADDR_HI;
                    end
                    ssram_pkg::CMD_WRITE: begin
                        n_kind  = KIND_WRITE;
                        n_phase = PH_ADDR_HI;
                    end
                    ssram_pkg::CMD_RDMODE: n_phase = PH_MODE_SHOW;
                    ssram_pkg::CMD_WRMODE: n_phase = PH_MODE_LOAD;
                    default:               n_phase = PH_SKIP;
                endcase
            end else begin
                unique case (r_phase)
                    PH_ADDR_HI: begin
                        n_addr  = w_shift[ADDR_BITS-1:0];
                        n_phase = PH_ADDR_MID;
                    end
                    PH_ADDR_MID: begin
                        n_addr  = w_shift[ADDR_BITS-1:0];
                        n_phase = PH_ADDR_LO;
                    end
                    PH_ADDR_LO: begin
                        n_addr  = w_shift[ADDR_BITS-1:0];
                        n_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        if (r_kind == KIND_READ) begin
                            w_step.rd_en = 1'b1;
                            w_step.reply = ssram_pkg::REPLY_MEM;
                        end else if (r_kind == KIND_WRITE) begin
                            w_step.wr_en = 1'b1;
                        end
                        n_addr = r_addr + 1'b1;
                    end
                    PH_MODE_LOAD: begin
                        n_mode  = i_byte[7:6];
                        n_phase = PH_SKIP;
                    end
                    PH_MODE_SHOW: w_step.reply = ssram_pkg::REPLY_MODE;
                    PH_IDLE, PH_SKIP: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= KIND_NONE;
            r_addr  <= '0;
            r_mode  <= ssram_pkg::MODE_SEQUENTIAL;
        end else begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_addr  <= n_addr;
            r_mode  <= n_mode;
        end
    end

    assign o_step = w_step;
    assign o_addr = r_addr;
    assign o_mode = r_mode;

endmodule

// ----- rtl/ssram_chk.sv -----
`include "spi_serial_sram_slave_unit_defines.svh"

module ssram_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    `SSRAM_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

    `SSRAM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output word changed")

    `SSRAM_ASSERT(a_ready_only_on_stall, !s_axis_tready |-> m_axis_tvalid, "input stalled with empty output")

    `SSRAM_ASSERT(a_latency, s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid, "answer word late")

endmodule

bind spi_serial_sram_slave_unit ssram_chk u_ssram_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- dv/spi_serial_sram_slave_unit_tb.sv -----
`timescale 1ns / 100ps

module spi_serial_sram_slave_unit_tb;

    localparam int ADDR_BITS    = 17;
    localparam int MEM_WORDS    = 1 << ADDR_BITS;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_WORDS = 400;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR_HI,
        ST_ADDR_MID,
        ST_ADDR_LO,
        ST_DATA,
        ST_MODE_LOAD,
        ST_MODE_SHOW,
        ST_SKIP
    } t_sram_phase;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_READ,
        ACC_WRITE
    } t_access_kind;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] data_byte;
    } t_spi_word;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_axis_tuser  = 1'b0;    // [0] frame_start
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte

    spi_serial_sram_slave_unit #(
        .ADDR_BITS(ADDR_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // predictor state
    logic [7:0]           mem_model [0:MEM_WORDS-1];
    logic [ADDR_BITS-1:0] cur_addr  = '0;
    t_sram_phase          sram_phase = ST_IDLE;
    t_access_kind         acc_kind  = ACC_NONE;
    logic [1:0]           mode_reg  = ssram_pkg::MODE_SEQUENTIAL;

    // stimulus-side bookkeeping: which locations have been written so far
    bit                   written_map [0:MEM_WORDS-1];
    logic [ADDR_BITS-1:0] write_starts [$];

    t_spi_word  pending_words [$];
    logic [7:0] answer_q [$];

    int err_count   = 0;
    int cycle_count = 0;
    int words_sent  = 0;
    int live_words  = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic predict_answer(input logic start, input logic [7:0] b);
        logic [7:0]           ans;
        logic [ADDR_BITS+7:0] shifted;
        ans = 8'h00;
        if (start) begin
            acc_kind = ACC_NONE;
            case (b)
                ssram_pkg::CMD_READ: begin
                    acc_kind   = ACC_READ;
                    sram_phase = ST_ADDR_HI;
                end
                ssram_pkg::CMD_WRITE: begin
                    acc_kind   = ACC_WRITE;
                    sram_phase = ST_ADDR_HI;
                end
                ssram_pkg::CMD_RDMODE: sram_phase = ST_MODE_SHOW;
                ssram_pkg::CMD_WRMODE: sram_phase = ST_MODE_LOAD;
                default:               sram_phase = ST_SKIP;
            endcase
        end else begin
            case (sram_phase)
                ST_ADDR_HI, ST_ADDR_MID, ST_ADDR_LO: begin
                    // high address bits fall off the top
                    shifted  = {cur_addr, b};
                    cur_addr = shifted[ADDR_BITS-1:0];
                    if (sram_phase == ST_ADDR_HI)
                        sram_phase = ST_ADDR_MID;
                    else if (sram_phase == ST_ADDR_MID)
                        sram_phase = ST_ADDR_LO;
                    else
                        sram_phase = ST_DATA;
                end
                ST_DATA: begin
                    if (acc_kind == ACC_READ)
                        ans = mem_model[cur_addr];
                    else if (acc_kind == ACC_WRITE)
                        mem_model[cur_addr] = b;
                    cur_addr = cur_addr + 1'b1;
                end
                ST_MODE_LOAD: begin
                    mode_reg   = b[7:6];
                    sram_phase = ST_SKIP;
                end
                ST_MODE_SHOW: ans = {mode_reg, 6'b0};
                default: ;
            endcase
        end
        answer_q.push_back(ans);
    endtask

    task automatic push_word(input logic start, input logic [7:0] b, input bit counted);
        t_spi_word w;
        w.frame_start = start;
        w.data_byte   = b;
        pending_words.push_back(w);
        if (counted)
            live_words++;
    endtask

    // cut < 3 truncates the address and leaves the frame there
    task automatic add_address(input logic [23:0] addr24, input int cut);
        if (cut > 0) push_word(1'b0, addr24[23:16], 1'b1);
        if (cut > 1) push_word(1'b0, addr24[15:8], 1'b1);
        if (cut > 2) push_word(1'b0, addr24[7:0], 1'b1);
    endtask

    task automatic add_write(input logic [23:0] addr24, input int len);
        logic [ADDR_BITS-1:0] a;
        push_word(1'b1, ssram_pkg::CMD_WRITE, 1'b1);
        add_address(addr24, 3);
        a = addr24[ADDR_BITS-1:0];
        write_starts.push_back(a);
        for (int k = 0; k < len; k++) begin
            push_word(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            written_map[a] = 1'b1;
            a = a + 1'b1;
        end
    endtask

    // stops short of any location not yet written
    task automatic add_read(input logic [23:0] addr24, input int len);
        logic [ADDR_BITS-1:0] a;
        push_word(1'b1, ssram_pkg::CMD_READ, 1'b1);
        add_address(addr24, 3);
        a = addr24[ADDR_BITS-1:0];
        for (int k = 0; k < len && written_map[a]; k++) begin
            push_word(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            a = a + 1'b1;
        end
    endtask

    task automatic add_extra(input int n, input bit counted);
        for (int k = 0; k < n; k++)
            push_word(1'b0, 8'($urandom_range(0, 255)), counted);
    endtask

    function automatic logic [23:0] pick_address(input logic [ADDR_BITS-1:0] eff);
        logic [23:0] a;
        a = 24'($urandom());
        a[ADDR_BITS-1:0] = eff;
        return a;
    endfunction

    // driver
    int   burst_left = 1;
    int   gap_left   = 0;
    logic tx_took;
    logic tx_next;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tuser  <= 1'b0;
            burst_left    = $urandom_range(1, 20);
            gap_left      = 0;
        end else begin
            tx_took = s_axis_tvalid && s_axis_tready;
            if (tx_took) begin
                predict_answer(pending_words[0].frame_start, pending_words[0].data_byte);
                void'(pending_words.pop_front());
                words_sent++;
            end
            if (s_axis_tvalid && !tx_took) begin
                tx_next = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                tx_next = 1'b0;
            end else if (pending_words.size() > 0) begin
                tx_next = 1'b1;
                s_axis_tdata <= pending_words[0].data_byte;
                s_axis_tuser <= pending_words[0].frame_start;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 7);
                end
            end else begin
                tx_next = 1'b0;
            end
            s_axis_tvalid <= tx_next;
        end
    end

    // monitor and receiver stall pattern
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   seg_left  = 0;
    int   rx_mode   = 0;
    logic rx_next;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch($sformatf("out_byte %02h with no word expected",
                                              m_axis_tdata));
                end else begin
                    if (m_axis_tdata !== answer_q[0])
                        report_mismatch($sformatf("out_byte got %02h expected %02h",
                                                  m_axis_tdata, answer_q[0]));
                    void'(answer_q.pop_front());
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rx_next = 1'b0;
            end else if (!hold_done && words_sent >= HOLD_AFTER) begin
                // long back-pressure so the pipeline fills and input stalls
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rx_next   = 1'b0;
            end else begin
                if (seg_left <= 0) begin
                    seg_left = $urandom_range(10, 60);
                    rx_mode  = $urandom_range(0, 2);
                end
                seg_left--;
                case (rx_mode)
                    0:       rx_next = 1'b1;
                    1:       rx_next = 1'($urandom_range(0, 1));
                    default: rx_next = ((cycle_count % 4) != 3);
                endcase
            end
            m_axis_tready <= rx_next;
        end
    end

    initial begin
        logic [7:0]           cmd;
        logic [ADDR_BITS-1:0] eff;
        int                   pick;
        int                   len;

        // directed: bytes before any command, mode read at reset value,
        // write and read across the top of memory with high address bits set,
        // reserved mode value, then an unknown command
        push_word(1'b0, 8'h00, 1'b1);
        push_word(1'b0, 8'hFF, 1'b1);
        push_word(1'b1, ssram_pkg::CMD_RDMODE, 1'b1);
        push_word(1'b0, 8'hFF, 1'b1);
        push_word(1'b1, ssram_pkg::CMD_WRITE, 1'b1);
        add_address(24'hFFFFFE, 3);
        push_word(1'b0, 8'h00, 1'b1);
        push_word(1'b0, 8'hFF, 1'b1);
        push_word(1'b0, 8'hA5, 1'b1);
        push_word(1'b0, 8'h5A, 1'b1);
        for (int k = 0; k < 4; k++)
            written_map[ADDR_BITS'(MEM_WORDS - 2 + k)] = 1'b1;
        write_starts.push_back(ADDR_BITS'(MEM_WORDS - 2));
        add_read(pick_address(ADDR_BITS'(MEM_WORDS - 2)), 4);
        push_word(1'b1, ssram_pkg::CMD_WRMODE, 1'b1);
        push_word(1'b0, 8'hC0, 1'b1);
        push_word(1'b0, 8'h40, 1'b1);
        push_word(1'b1, ssram_pkg::CMD_RDMODE, 1'b1);
        push_word(1'b0, 8'h00, 1'b1);
        push_word(1'b1, 8'hFF, 1'b1);
        push_word(1'b0, 8'h03, 1'b1);

        live_words = 0;
        while (live_words < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 30 || (pick < 60 && write_starts.size() == 0)) begin
                case ($urandom_range(0, 3))
                    0:       eff = ADDR_BITS'($urandom_range(0, 63));
                    1:       eff = ADDR_BITS'(MEM_WORDS - 1 - $urandom_range(0, 7));
                    default: eff = ADDR_BITS'($urandom());
                endcase
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
                                                  : $urandom_range(1, 6);
                add_write(pick_address(eff), len);
            end else if (pick < 60) begin
                eff = write_starts[$urandom_range(0, write_starts.size() - 1)]
                      + ADDR_BITS'($urandom_range(0, 3));
                add_read(pick_address(eff), $urandom_range(1, 8));
            end else if (pick < 68) begin
                push_word(1'b1, ssram_pkg::CMD_RDMODE, 1'b1);
                add_extra($urandom_range(1, 3), 1'b1);
            end else if (pick < 76) begin
                push_word(1'b1, ssram_pkg::CMD_WRMODE, 1'b1);
                add_extra($urandom_range(1, 3), 1'b1);
                add_extra($urandom_range(0, 2), 1'b0);
            end else if (pick < 86) begin
                do
                    cmd = 8'($urandom_range(0, 255));
                while (cmd == ssram_pkg::CMD_READ || cmd == ssram_pkg::CMD_WRITE ||
                       cmd == ssram_pkg::CMD_RDMODE || cmd == ssram_pkg::CMD_WRMODE);
                push_word(1'b1, cmd, 1'b1);
                add_extra($urandom_range(0, 3), 1'b1);
                add_extra($urandom_range(0, 2), 1'b0);
            end else begin
                // frame cut short inside the address
                push_word(1'b1,
                          ($urandom_range(0, 1) == 0) ? ssram_pkg::CMD_READ
                                                      : ssram_pkg::CMD_WRITE,
                          1'b1);
                add_address(24'($urandom()), $urandom_range(0, 2));
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(pending_words.size() == 0 && !s_axis_tvalid && answer_q.size() == 0)
               && cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (answer_q.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived", answer_q.size()));
        if (cycle_count >= CYCLE_LIMIT || err_count != 0)
            $display("Regression FAIL");
        else
            $display("Regression PASS");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ssram_pkg.sv
rtl/ssram_ram.sv
rtl/ssram_ctrl.sv
rtl/spi_serial_sram_slave_unit.sv
rtl/ssram_chk.sv
dv/spi_serial_sram_slave_unit_tb.sv
